FILE: src/dad_pkg.sv
`default_nettype none

package dad_pkg;

    // Width of the day count on the input port.
    localparam int COUNT_WIDTH = 16;

    // Field widths fixed by the port list.
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_OUT_W = 14;

    // Calendar constants.
    localparam int YEAR_CYCLE       = 400;
    localparam int CENTURY          = 100;
    localparam int LEAP_YEAR_DAYS   = 366;
    localparam int COMMON_YEAR_DAYS = 365;
    localparam int LEAP_FEB_DAYS    = 29;
    localparam int YEAR_LIMIT       = 9999;
    localparam int MONTHS           = 12;
    localparam int FEBRUARY         = 2;

    // Running day total must hold a full leap year plus the largest count.
    localparam int TOTAL_W = ((COUNT_WIDTH > 9) ? COUNT_WIDTH : 9) + 1;

    // Internal year must hold the largest reachable year exactly.
    localparam int YEAR_END_MAX = YEAR_LIMIT + ((1 << COUNT_WIDTH) / COMMON_YEAR_DAYS) + 1;
    localparam int YEAR_CLOG    = $clog2(YEAR_END_MAX + 1);
    localparam int YEAR_W       = (YEAR_CLOG > YEAR_OUT_W) ? YEAR_CLOG : YEAR_OUT_W;

    // Position of the year inside the 400-year Gregorian cycle.
    localparam int CYCLE_W = $clog2(YEAR_CYCLE);

    typedef logic [DAY_W-1:0] t_month_len [MONTHS];

    localparam t_month_len MONTH_DAYS = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_DOY,
        ST_YEAR,
        ST_MON
    } t_state;

    // Leap rule evaluated on the year's place in the 400-year cycle.
    function automatic logic is_leap(input logic [CYCLE_W-1:0] pos);
        logic century;
        century = (pos == CYCLE_W'(CENTURY)) || (pos == CYCLE_W'(2 * CENTURY)) ||
                  (pos == CYCLE_W'(3 * CENTURY));
        return (pos[1:0] == 2'b00) && !century;
    endfunction

    // Length of a month; months outside 1..12 give zero.
    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                     input logic              leap);
        logic [MONTH_W-1:0] idx;
        logic [DAY_W-1:0]   len;
        idx = month - MONTH_W'(1);
        len = '0;
        if (month == MONTH_W'(FEBRUARY) && leap) begin
            len = DAY_W'(LEAP_FEB_DAYS);
        end else if (month >= MONTH_W'(1) && month <= MONTH_W'(MONTHS)) begin
            len = MONTH_DAYS[idx];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: src/date_add_days.sv
// Steps: the year is reduced modulo 400, the date is checked, the months before the start
//   month and the day count are added to build the day total, whole years are stepped off
//   and the months are split off; a bad date ends after the check.
// Throughput: one item at a time; busy drops as the result strobe rises, so a new start
//   beat can be taken on the next edge. The receiver cannot stall the result beat.
// Reset: synchronous, active low; clears the sequencer and the result strobe.
`default_nettype none

module date_add_days
    import dad_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [DAY_W-1:0]       i_start_day,
    input  wire logic [MONTH_W-1:0]     i_start_month,
    input  wire logic [YEAR_OUT_W-1:0]  i_start_year,
    input  wire logic [COUNT_WIDTH-1:0] i_days_to_add,
    output logic                        o_valid,
    output logic [DAY_W-1:0]            o_end_day,
    output logic [MONTH_W-1:0]          o_end_month,
    output logic [YEAR_OUT_W-1:0]       o_end_year,
    output logic                        o_bad_date
);

    t_state                   r_state, n_state;
    logic                     r_valid, n_valid;
    logic [DAY_W-1:0]         r_day;
    logic [MONTH_W-1:0]       r_month;
    logic [COUNT_WIDTH-1:0]   r_count;
    logic [YEAR_W-1:0]        r_year, n_year;
    logic [YEAR_OUT_W-1:0]    r_ymod, n_ymod;
    logic [TOTAL_W-1:0]       r_total, n_total;
    logic [MONTH_W-1:0]       r_mcnt, n_mcnt;
    logic [DAY_W-1:0]         r_out_day, n_out_day;
    logic [MONTH_W-1:0]       r_out_month, n_out_month;
    logic [YEAR_OUT_W-1:0]    r_out_year, n_out_year;
    logic                     r_out_bad, n_out_bad;

    logic                     accept;
    logic                     leap;
    logic                     mod_done;
    logic                     doy_more;
    logic                     date_ok;
    logic [DAY_W-1:0]         cur_dim;
    logic [TOTAL_W-1:0]       op_b;
    logic                     op_sub;
    logic [TOTAL_W-1:0]       unit_res;
    logic                     unit_gt;
    logic                     mon_step;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    // Leap flag of the year being worked on.
    assign leap     = is_leap(r_ymod[CYCLE_W-1:0]);
    assign mod_done = (r_ymod < YEAR_OUT_W'(YEAR_CYCLE));
    assign cur_dim  = days_in_month(r_mcnt, leap);
    assign doy_more = (r_mcnt < r_month);

    // The start date is valid when month, year and day all lie in range.
    assign date_ok = (r_month >= MONTH_W'(1)) && (r_month <= MONTH_W'(MONTHS)) &&
                     (r_year >= YEAR_W'(1)) && (r_year <= YEAR_W'(YEAR_LIMIT)) &&
                     (r_day >= DAY_W'(1)) && (r_day <= days_in_month(r_month, leap));

    // Operand selection for the shared unit.
    always_comb begin
        op_b   = '0;
        op_sub = 1'b0;
        unique case (r_state)
            ST_DOY: begin
                op_b = doy_more ? TOTAL_W'(cur_dim) : TOTAL_W'(r_count);
            end
            ST_YEAR: begin
                op_b   = leap ? TOTAL_W'(LEAP_YEAR_DAYS) : TOTAL_W'(COMMON_YEAR_DAYS);
                op_sub = 1'b1;
            end
            ST_MON: begin
                op_b   = TOTAL_W'(cur_dim);
                op_sub = 1'b1;
            end
            default: begin
                op_b   = '0;
                op_sub = 1'b0;
            end
        endcase
    end

    // Shared add/subtract and compare unit on the day total.
    assign unit_res = op_sub ? (r_total - op_b) : (r_total + op_b);
    assign unit_gt  = (r_total > op_b);
    assign mon_step = (r_mcnt < MONTH_W'(MONTHS)) && unit_gt;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_MOD;
            end
            ST_MOD: begin
                if (mod_done) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = date_ok ? ST_DOY : ST_IDLE;
            end
            ST_DOY: begin
                if (!doy_more) n_state = ST_YEAR;
            end
            ST_YEAR: begin
                if (!unit_gt) n_state = ST_MON;
            end
            ST_MON: begin
                if (!mon_step) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and result updates for each state.
    always_comb begin
        n_valid     = 1'b0;
        n_year      = r_year;
        n_ymod      = r_ymod;
        n_total     = r_total;
        n_mcnt      = r_mcnt;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;
        n_out_bad   = r_out_bad;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_year = YEAR_W'(i_start_year);
                    n_ymod = i_start_year;
                end
            end
            ST_MOD: begin
                if (!mod_done) n_ymod = r_ymod - YEAR_OUT_W'(YEAR_CYCLE);
            end
            ST_CHECK: begin
                n_total = TOTAL_W'(r_day);
                n_mcnt  = MONTH_W'(1);
                if (!date_ok) begin
                    n_valid     = 1'b1;
                    n_out_day   = '0;
                    n_out_month = '0;
                    n_out_year  = '0;
                    n_out_bad   = 1'b1;
                end
            end
            ST_DOY: begin
                n_total = unit_res;
                if (doy_more) n_mcnt = r_mcnt + MONTH_W'(1);
            end
            ST_YEAR: begin
                if (unit_gt) begin
                    n_total = unit_res;
                    n_year  = r_year + YEAR_W'(1);
                    n_ymod  = (r_ymod == YEAR_OUT_W'(YEAR_CYCLE - 1)) ? '0
                                                                      : r_ymod + YEAR_OUT_W'(1);
                end else begin
                    n_mcnt = MONTH_W'(1);
                end
            end
            ST_MON: begin
                if (mon_step) begin
                    n_total = unit_res;
                    n_mcnt  = r_mcnt + MONTH_W'(1);
                end else begin
                    n_valid     = 1'b1;
                    n_out_day   = r_total[DAY_W-1:0];
                    n_out_month = r_mcnt;
                    n_out_year  = r_year[YEAR_OUT_W-1:0];
                    n_out_bad   = 1'b0;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_day   <= i_start_day;
            r_month <= i_start_month;
            r_count <= i_days_to_add;
        end
        r_year      <= n_year;
        r_ymod      <= n_ymod;
        r_total     <= n_total;
        r_mcnt      <= n_mcnt;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
        r_out_bad   <= n_out_bad;
    end

    assign o_valid     = r_valid;
    assign o_end_day   = r_out_day;
    assign o_end_month = r_out_month;
    assign o_end_year  = r_out_year;
    assign o_bad_date  = r_out_bad;

    // A bad date beat carries an all-zero date.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_date |-> (o_end_day == '0) && (o_end_month == '0) &&
                                  (o_end_year == '0))
        else $error("bad date beat carries a nonzero date");

    // A good result names a real month and a nonzero day.
    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_date |-> (o_end_month >= MONTH_W'(1)) &&
                                   (o_end_month <= MONTH_W'(MONTHS)) &&
                                   (o_end_day != '0))
        else $error("result date out of range");

    // An accepted start makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted start did not raise busy");

    // Results never come back to back.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire
